@@ src/asav_pkg.sv @@
package asav_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int CH_BITS      = $clog2(NUM_CHANNELS);
   localparam int MASK_BITS    = 8;
   localparam int ACC_BITS     = SAMPLE_BITS + 2;
   localparam int CNT_BITS     = 3;
   // one discarded conversion, then this many summed
   localparam int AVG_SAMPLES  = 4;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                command;
      logic [SAMPLE_BITS-1:0] sample;
      logic [CH_BITS-1:0]     read_channel;
   } req_type;

   typedef struct packed {
      logic                   average_done;
      logic [CH_BITS-1:0]     done_channel;
      logic [SAMPLE_BITS-1:0] average_value;
      logic [CH_BITS-1:0]     mux_channel;
      logic [SAMPLE_BITS-1:0] read_value;
      logic                   read_valid;
   } rsp_type;

endpackage

@@ src/adc_scan_average_sequencer.sv @@
// channel   direction  handshake          payload
// req_      in         req_valid/stall    asav_pkg::req_type (command, sample, read_channel)
// rsp_      out        rsp_valid/stall    asav_pkg::rsp_type (one item per req item)
// csr_      in         csr_valid/ready    channel_mask, 8 bits
//
// One item per cycle unless req_stall; each accepted item is registered before rsp_valid.
// Scan state and channel averages update at the accept edge; rsp is a
// two-entry output register (output + skid), so req_stall is registered.
// Synchronous active-high reset clears mask, scan state and valid bits.
// csr_ready is always high; a mask write restarts the scan.
module adc_scan_average_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  asav_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output asav_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [asav_pkg::MASK_BITS-1:0] csr_data
);
   import asav_pkg::*;

   logic    item_accept;
   logic    csr_write;
   rsp_type result;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign item_accept = req_valid && !req_stall;

   asav_scan_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .item_accept (item_accept),
      .item        (req_data),
      .result      (result)
   );

   asav_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

@@ src/asav_scan_core.sv @@
module asav_scan_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [asav_pkg::MASK_BITS-1:0]   csr_data,
   input  logic                             item_accept,
   input  asav_pkg::req_type                item,
   output asav_pkg::rsp_type                result
);
   import asav_pkg::*;

   logic [MASK_BITS-1:0]   mask_ff;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [CH_BITS-1:0]     cur_ff, cur_in;
   logic [SAMPLE_BITS-1:0] avg_mem_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;

   logic [ACC_BITS-1:0]    acc_sum;
   logic [CNT_BITS-1:0]    cnt_next;
   logic                   sample_taken;
   logic                   complete;

   function automatic logic [CH_BITS-1:0] next_enabled(
      input logic [MASK_BITS-1:0] mask,
      input logic [CH_BITS-1:0]   from
   );
      logic [CH_BITS-1:0] pick;
      logic [CH_BITS-1:0] c;
      pick = from;
      // walk downward so the nearest channel after 'from' wins
      for (int i = NUM_CHANNELS; i >= 1; i--) begin
         c = from + CH_BITS'(i);
         if (mask[c]) pick = c;
      end
      return pick;
   endfunction

   function automatic logic [CH_BITS-1:0] lowest_enabled(input logic [MASK_BITS-1:0] mask);
      logic [CH_BITS-1:0] pick;
      pick = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (mask[i]) pick = CH_BITS'(i);
      end
      return pick;
   endfunction

   always_comb begin
      sample_taken = item_accept && (item.command == CMD_SAMPLE) && (mask_ff != '0);
      acc_sum      = (cnt_ff != '0) ? acc_ff + ACC_BITS'(item.sample) : acc_ff;
      cnt_next     = cnt_ff + CNT_BITS'(1);
      complete     = sample_taken && (cnt_next > CNT_BITS'(AVG_SAMPLES));

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      if (sample_taken) begin
         if (complete) begin
            acc_in = '0;
            cnt_in = '0;
            cur_in = next_enabled(mask_ff, cur_ff);
         end else begin
            acc_in = acc_sum;
            cnt_in = cnt_next;
         end
      end

      result = '0;
      result.mux_channel = cur_in;
      if (item.command == CMD_READ) begin
         if (valid_ff[item.read_channel]) begin
            result.read_value = avg_mem_ff[item.read_channel];
            result.read_valid = 1'b1;
         end
      end else if (complete) begin
         result.average_done  = 1'b1;
         result.done_channel  = cur_ff;
         result.average_value = acc_sum[ACC_BITS-1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         valid_ff <= '0;
      end else if (csr_write) begin
         mask_ff <= csr_data;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         cur_ff  <= lowest_enabled(csr_data);
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         cur_ff <= cur_in;
         if (complete) valid_ff[cur_ff] <= 1'b1;
      end
   end

   // averages need no reset: an entry is only read once its valid bit is set
   always_ff @(posedge clock) begin
      if (complete && !csr_write) begin
         avg_mem_ff[cur_ff] <= acc_sum[ACC_BITS-1:2];
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(AVG_SAMPLES))
      else $error("sample count beyond averaging window");

   a_cur_enabled: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != '0) |-> mask_ff[cur_ff])
      else $error("selected channel not enabled");

   a_complete_clears: assert property (@(posedge clock) disable iff (reset)
      (complete && !csr_write) |=> (cnt_ff == '0) && (acc_ff == '0))
      else $error("accumulator not cleared after average");

   a_complete_marks: assert property (@(posedge clock) disable iff (reset)
      (complete && !csr_write) |=> valid_ff[$past(cur_ff)])
      else $error("completed channel not marked valid");

endmodule

@@ src/asav_rsp_buf.sv @@
module asav_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  asav_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output asav_pkg::rsp_type out_data
);
   import asav_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;
   logic    accept;

   assign take      = out_valid_ff && !out_stall;
   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid && !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> !skid_valid_ff && (out_data_ff == $past(skid_data_ff)))
      else $error("skid item not moved to output");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stall) |=> out_valid_ff && $stable(out_data_ff))
      else $error("pending item lost");

endmodule
